@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is held
`define RSSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds while reset is held
`define RSSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSSG_ASSERT(lbl, prop, msg)
`define RSSG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/rssg_pkg.sv @@
// types, constants and register codes of the rms sound segment gate
`timescale 1ns / 1ps

package rssg_pkg;

  localparam int MAX_BUFFER  = 4096;
  localparam int COUNT_WIDTH = 20;
  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 15;
  localparam int FIELD_W     = 20;
  localparam int CFG_W       = 20;
  localparam int CNT_W       = $clog2(MAX_BUFFER + 1);
  localparam int SQ_W        = 2 * SAMPLE_W - 1;
  localparam int SUM_W       = SQ_W + CNT_W - 1;
  localparam int ROOT_W      = (SQ_W + 1) / 2;
  localparam int DIV_STEPS   = SUM_W;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  localparam logic [LEVEL_W-1:0] SOUND_THR_RST    = LEVEL_W'(1638);
  localparam logic [LEVEL_W-1:0] SILENCE_THR_RST  = LEVEL_W'(655);
  localparam logic [FIELD_W-1:0] MIN_DURATION_RST = FIELD_W'(2400);
  localparam logic [FIELD_W-1:0] MIN_SEGMENT_RST  = FIELD_W'(1024);

  typedef enum logic [1:0] {
    REG_SOUND_THR    = 2'd0,
    REG_SILENCE_THR  = 2'd1,
    REG_MIN_DURATION = 2'd2,
    REG_MIN_SEGMENT  = 2'd3
  } rssg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_buffer;
  } rssg_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic               sound_open;
    logic               segment_closed;
    logic               segment_valid;
    logic [FIELD_W-1:0] segment_length;
    logic [FIELD_W-1:0] segment_elapsed;
  } rssg_out_t;

  typedef enum logic [2:0] {
    GT_IDLE   = 3'd0,
    GT_MUL    = 3'd1,
    GT_ADD    = 3'd2,
    GT_CALC   = 3'd3,
    GT_DECIDE = 3'd4
  } rssg_gate_state_t;

  typedef enum logic [1:0] {
    DS_IDLE = 2'd0,
    DS_DIV  = 2'd1,
    DS_SQRT = 2'd2
  } rssg_ds_state_t;

  // handshake between the gate sequencer and the divide / root unit
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
  } rssg_ds_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } rssg_ds_rsp_t;

endpackage

@@ rtl/core/rms_sound_segment_gate_top.sv @@
// rms sound segment gate: square accumulation, rms per buffer and hysteresis gate
`timescale 1ns / 1ps

// One audio sample word is taken at a time and the input stalls until it is
// fully processed. A sample that does not end its buffer is accepted, squared
// and accumulated. A sample that ends its buffer is squared and summed, then
// passes 43 restoring-divide steps and 16 square-root steps through the single
// subtract-compare unit of the divide / root sequencer; the root is handed back
// and the threshold decision is made. The result word sits in an output
// register, so the next sample is taken while it waits; only a second buffer
// end finding that register still full waits for it. A buffer ends on the
// last_in_buffer flag or at 4096 samples.

`include "assert_macros.svh"

module rms_sound_segment_gate_top import rssg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rssg_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rssg_out_t          out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  rssg_gate_state_t       state_r, state_nxt;
  logic [LEVEL_W-1:0]     snd_thr_r, sil_thr_r;
  logic [FIELD_W-1:0]     min_dur_r, min_seg_r;
  logic [SAMPLE_W-1:0]    mag_r, mag_nxt;
  logic                   last_r, last_nxt;
  logic [SQ_W-1:0]        prod_r, prod_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic                   in_seg_r, in_seg_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0] loud_r, loud_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rssg_out_t              out_data_r, out_data_nxt;

  rssg_ds_req_t           ds_req;
  rssg_ds_rsp_t           ds_rsp;

  logic [CNT_W-1:0]       cnt_inc;
  logic                   buf_end;
  logic [SUM_W-1:0]       sum_add;
  logic [LEVEL_W-1:0]     rms;
  logic                   is_loud, is_quiet, closing, slot_free;
  logic [COUNT_WIDTH-1:0] loud_base;
  logic [COUNT_WIDTH:0]   loud_sum;
  logic [COUNT_WIDTH-1:0] loud_sat;
  logic [SQ_W-1:0]        mag_sq;

  rssg_divsqrt u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ds_req),
    .divisor (n_r),
    .rsp     (ds_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snd_thr_r <= SOUND_THR_RST;
      sil_thr_r <= SILENCE_THR_RST;
      min_dur_r <= MIN_DURATION_RST;
      min_seg_r <= MIN_SEGMENT_RST;
    end else if (cfg_we) begin
      case (rssg_reg_t'(cfg_index))
        REG_SOUND_THR:    snd_thr_r <= cfg_wdata[LEVEL_W-1:0];
        REG_SILENCE_THR:  sil_thr_r <= cfg_wdata[LEVEL_W-1:0];
        REG_MIN_DURATION: min_dur_r <= cfg_wdata[FIELD_W-1:0];
        REG_MIN_SEGMENT:  min_seg_r <= cfg_wdata[FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign mag_sq  = SQ_W'(mag_r * mag_r);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign buf_end = last_r || (cnt_inc == CNT_W'(MAX_BUFFER));
  assign sum_add = sum_r + {{(SUM_W-SQ_W){1'b0}}, prod_r};

  // full-scale level saturates
  assign rms      = ds_rsp.root[ROOT_W-1] ? {LEVEL_W{1'b1}} : ds_rsp.root[LEVEL_W-1:0];
  assign is_loud  = rms > snd_thr_r;
  assign is_quiet = rms < sil_thr_r;
  assign closing  = !is_loud && in_seg_r && is_quiet;
  assign slot_free = !out_valid_r || !out_stall;

  // onset starts the loud count from zero
  assign loud_base = in_seg_r ? loud_r : '0;
  assign loud_sum  = {1'b0, loud_base} + {{(COUNT_WIDTH+1-CNT_W){1'b0}}, n_r};
  assign loud_sat  = loud_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : loud_sum[COUNT_WIDTH-1:0];

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    in_seg_nxt    = in_seg_r;
    elapsed_nxt   = elapsed_r;
    loud_nxt      = loud_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ds_req.start    = 1'b0;
    ds_req.dividend = sum_add;
    in_stall      = (state_r != GT_IDLE);
    case (state_r)
      GT_IDLE: begin
        if (in_valid) begin
          mag_nxt   = in_data.sample[SAMPLE_W-1] ? SAMPLE_W'(-in_data.sample)
                                                 : SAMPLE_W'(in_data.sample);
          last_nxt  = in_data.last_in_buffer;
          state_nxt = GT_MUL;
        end
      end
      GT_MUL: begin
        prod_nxt  = mag_sq;
        state_nxt = GT_ADD;
      end
      GT_ADD: begin
        if (in_seg_r && (elapsed_r != {COUNT_WIDTH{1'b1}})) begin
          elapsed_nxt = elapsed_r + COUNT_WIDTH'(1);
        end
        if (buf_end) begin
          ds_req.start = 1'b1;
          n_nxt     = cnt_inc;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = GT_CALC;
        end else begin
          sum_nxt   = sum_add;
          cnt_nxt   = cnt_inc;
          state_nxt = GT_IDLE;
        end
      end
      GT_CALC: begin
        if (ds_rsp.done) begin
          state_nxt = GT_DECIDE;
        end
      end
      GT_DECIDE: begin
        if (slot_free) begin
          out_data_nxt.rms_level       = rms;
          out_data_nxt.segment_closed  = closing;
          out_data_nxt.segment_valid   = closing && (elapsed_r > min_dur_r)
                                                 && (loud_r > min_seg_r);
          out_data_nxt.sound_open      = in_seg_r;
          out_data_nxt.segment_length  = '0;
          out_data_nxt.segment_elapsed = '0;
          if (is_loud) begin
            in_seg_nxt  = 1'b1;
            loud_nxt    = loud_sat;
            out_data_nxt.sound_open      = 1'b1;
            out_data_nxt.segment_length  = loud_sat;
            out_data_nxt.segment_elapsed = in_seg_r ? elapsed_r : '0;
            if (!in_seg_r) begin
              elapsed_nxt = '0;
            end
          end else if (closing) begin
            in_seg_nxt = 1'b0;
            out_data_nxt.sound_open      = 1'b0;
            out_data_nxt.segment_length  = loud_r;
            out_data_nxt.segment_elapsed = elapsed_r;
          end else if (in_seg_r) begin
            out_data_nxt.segment_length  = loud_r;
            out_data_nxt.segment_elapsed = elapsed_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = GT_IDLE;
        end
      end
      default: begin
        state_nxt = GT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= GT_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      in_seg_r    <= 1'b0;
      elapsed_r   <= '0;
      loud_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      in_seg_r    <= in_seg_nxt;
      elapsed_r   <= elapsed_nxt;
      loud_r      <= loud_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RSSG_ASSERT(a_close_shuts, out_valid |-> !(out_data.segment_closed && out_data.sound_open), "closed segment reported open")
  `RSSG_ASSERT(a_valid_needs_close, out_valid |-> (out_data.segment_closed || !out_data.segment_valid), "segment valid without close")
  `RSSG_ASSERT(a_idle_fields_zero, (out_valid && !out_data.sound_open && !out_data.segment_closed) |-> (out_data.segment_length == '0 && out_data.segment_elapsed == '0), "segment fields set with no segment")
  `RSSG_ASSERT(a_done_in_calc, ds_rsp.done |-> (state_r == GT_CALC), "root finished outside calc")
  `RSSG_ASSERT(a_count_bound, cnt_r < CNT_W'(MAX_BUFFER), "buffer count reached its limit")

endmodule

@@ rtl/core/rssg_divsqrt.sv @@
// shared subtract-compare unit: restoring divide then bit-pair square root
`timescale 1ns / 1ps

module rssg_divsqrt import rssg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rssg_ds_req_t       req,
  input  logic [CNT_W-1:0]   divisor,
  output rssg_ds_rsp_t       rsp
);

  rssg_ds_state_t    state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SQ_W-1:0]   v_r, v_nxt;
  logic [SQ_W-1:0]   root_r, root_nxt;
  logic [SQ_W-1:0]   bit_r, bit_nxt;
  logic              done_r, done_nxt;

  // the one shared unit
  logic [SQ_W-1:0]   op_a, op_b;
  logic [SQ_W:0]     diff;
  logic              ge;
  logic [CNT_W:0]    trial;
  logic [SUM_W-1:0]  dvd_shift;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = {1'b0, op_a} - {1'b0, op_b};
  assign ge    = ~diff[SQ_W];
  assign dvd_shift = {dvd_r[SUM_W-2:0], ge};

  always_comb begin
    op_a = {{(SQ_W-CNT_W-1){1'b0}}, trial};
    op_b = {{(SQ_W-CNT_W){1'b0}}, divisor};
    if (state_r == DS_SQRT) begin
      op_a = v_r;
      // root bits sit above the trial bit, so or is the sum
      op_b = root_r | bit_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    v_nxt     = v_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    case (state_r)
      DS_IDLE: begin
        if (req.start) begin
          dvd_nxt   = req.dividend;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(DIV_STEPS - 1);
          state_nxt = DS_DIV;
        end
      end
      DS_DIV: begin
        dvd_nxt = dvd_shift;
        rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          // quotient never needs more than the square width
          v_nxt     = dvd_shift[SQ_W-1:0];
          root_nxt  = '0;
          bit_nxt   = SQ_W'(1) << (SQ_W - 1);
          step_nxt  = STEP_W'(SQRT_STEPS - 1);
          state_nxt = DS_SQRT;
        end
      end
      DS_SQRT: begin
        if (ge) begin
          v_nxt    = diff[SQ_W-1:0];
          root_nxt = (root_r >> 1) | bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = DS_IDLE;
        end
      end
      default: begin
        state_nxt = DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r[ROOT_W-1:0];

endmodule
